[rtl/core/indexed_min_heap_queue_unit_defines.svh]
// Assertion macros shared by the heap queue RTL.
`ifndef INDEXED_MIN_HEAP_QUEUE_UNIT_DEFINES_SVH
`define INDEXED_MIN_HEAP_QUEUE_UNIT_DEFINES_SVH
`ifndef SYNTH
`define IMHQ_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
`define IMHQ_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);
`else
`define IMHQ_ASSERT(lbl, prop, msg)
`define IMHQ_NEVER(lbl, cond, msg)
`endif
`endif

[rtl/core/imhq_pkg.sv]
// Types and constants of the indexed min-heap queue.
package imhq_pkg;
   localparam int HEAP_SLOTS = 64;
   localparam int KEY_IDS = 64;
   localparam int PRIO_BITS = 32;
   localparam int KEY_W = $clog2(KEY_IDS);
   localparam int SLOT_AW = $clog2(HEAP_SLOTS);
   localparam int CNT_W = $clog2(HEAP_SLOTS + 1);
   localparam int REQ_W = 40;
   localparam int RSP_W = 88;

   typedef enum logic [1:0] {
      ACT_PUSH = 2'd0,
      ACT_POP = 2'd1,
      ACT_UPDATE = 2'd2,
      ACT_QUERY = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0,
      ST_FULL = 3'd1,
      ST_EMPTY = 3'd2,
      ST_ABSENT = 3'd3,
      ST_DUP = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_POS,
      S_POP_RD,
      S_UPD_RD,
      S_QRY_RD,
      S_UP,
      S_UP_CMP,
      S_DN,
      S_DN_L,
      S_DN_R,
      S_DN_CMP,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic signed [PRIO_BITS-1:0] prio;
   } slot_type;

   localparam int SLOT_W = $bits(slot_type);
endpackage

[rtl/core/imhq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module imhq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

[rtl/core/indexed_min_heap_queue_unit.sv]
// Indexed binary min-heap priority queue with per-key position table.
// One request beat returns one response beat. The heap slots and the key position table sit in
// two RAMs with registered read data, and a sequencer walks the heap one level at a time: a failed
// request goes straight to the response, a query reads its slot, a push or lowered update sifts
// up and a pop or raised update sifts down, at most the height of the 64-entry heap. A new request
// is taken while the previous response still waits.
module indexed_min_heap_queue_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // action[1:0], key_id[7:2], prio_value[39:8], zero fill above.
   input  logic [imhq_pkg::REQ_W-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // status[2:0], front_key[8:3], front_prio[40:9], heap_empty[41], item_count[48:42],
   // queried_prio[80:49], zero fill above.
   output logic [imhq_pkg::RSP_W-1:0] rsp_tdata
);
   import imhq_pkg::*;
`include "indexed_min_heap_queue_unit_defines.svh"

   state_type state_ff, state_in;
   action_type act_ff, act_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic signed [PRIO_BITS-1:0] prio_ff, prio_in;
   logic [CNT_W-1:0] cur_idx_ff, cur_idx_in, best_idx_ff, best_idx_in, count_ff, count_in;
   slot_type cur_ff, cur_in, best_ff, best_in, root_ff, root_in;
   status_type status_ff, status_in;
   logic signed [PRIO_BITS-1:0] queried_ff, queried_in;
   logic [KEY_IDS-1:0] pos_valid_ff, pos_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;

   logic slot_we, pos_we;
   logic [CNT_W-1:0] slot_widx, slot_ridx, slot_wtmp, slot_rtmp;
   slot_type slot_wdata, slot_rdata;
   logic [SLOT_AW-1:0] slot_waddr, slot_raddr;
   logic [KEY_W-1:0] pos_waddr, pos_raddr;
   logic [CNT_W-1:0] pos_wdata, pos_rdata, pos_eff;
   logic [CNT_W:0] left_idx, right_idx;
   logic accept, rsp_free;

   assign accept = req_tvalid && req_tready;
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign pos_eff = pos_valid_ff[key_ff] ? pos_rdata : '0;
   assign left_idx = {cur_idx_ff, 1'b0};
   assign right_idx = left_idx + 1'b1;
   assign slot_wtmp = slot_widx - 1'b1;
   assign slot_rtmp = slot_ridx - 1'b1;
   assign slot_waddr = slot_wtmp[SLOT_AW-1:0];
   assign slot_raddr = slot_rtmp[SLOT_AW-1:0];

   imhq_ram #(.WIDTH(SLOT_W), .DEPTH(HEAP_SLOTS)) u_slot_ram (
      .clock(clock), .wr_en(slot_we), .wr_addr(slot_waddr), .wr_data(slot_wdata),
      .rd_addr(slot_raddr), .rd_data(slot_rdata)
   );

   imhq_ram #(.WIDTH(CNT_W), .DEPTH(KEY_IDS)) u_pos_ram (
      .clock(clock), .wr_en(pos_we), .wr_addr(pos_waddr), .wr_data(pos_wdata),
      .rd_addr(pos_raddr), .rd_data(pos_rdata)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (accept) state_in = S_POS;
         S_POS: begin
            state_in = S_DONE;
            case (act_ff)
               ACT_PUSH: if (pos_eff == '0 && count_ff != CNT_W'(HEAP_SLOTS)) state_in = S_UP;
               ACT_POP: if (count_ff != '0) state_in = S_POP_RD;
               ACT_UPDATE: if (pos_eff != '0) state_in = S_UPD_RD;
               ACT_QUERY: if (pos_eff != '0) state_in = S_QRY_RD;
               default: state_in = S_DONE;
            endcase
         end
         S_POP_RD: state_in = (count_ff == CNT_W'(1)) ? S_DONE : S_DN;
         S_UPD_RD: state_in = (slot_rdata.prio < prio_ff) ? S_DN : S_UP;
         S_QRY_RD: state_in = S_DONE;
         S_UP: state_in = (cur_idx_ff == CNT_W'(1)) ? S_DONE : S_UP_CMP;
         S_UP_CMP: state_in = (cur_ff.prio < slot_rdata.prio) ? S_UP : S_DONE;
         S_DN: state_in = (left_idx > {1'b0, count_ff}) ? S_DONE : S_DN_L;
         S_DN_L: state_in = (right_idx <= {1'b0, count_ff}) ? S_DN_R : S_DN_CMP;
         S_DN_R: state_in = S_DN_CMP;
         S_DN_CMP: state_in = (best_ff.prio < cur_ff.prio) ? S_DN : S_DONE;
         S_DONE: if (rsp_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      act_in = act_ff;
      key_in = key_ff;
      prio_in = prio_ff;
      cur_idx_in = cur_idx_ff;
      cur_in = cur_ff;
      best_idx_in = best_idx_ff;
      best_in = best_ff;
      count_in = count_ff;
      status_in = status_ff;
      queried_in = queried_ff;
      pos_valid_in = pos_valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      slot_we = 1'b0;
      slot_widx = cur_idx_ff;
      slot_wdata = cur_ff;
      slot_ridx = cur_idx_ff;
      pos_we = 1'b0;
      pos_waddr = cur_ff.key;
      pos_wdata = cur_idx_ff;
      pos_raddr = req_tdata[7:2];
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               act_in = action_type'(req_tdata[1:0]);
               key_in = req_tdata[7:2];
               prio_in = req_tdata[39:8];
               status_in = ST_OK;
               queried_in = '0;
            end
         end
         S_POS: begin
            case (act_ff)
               ACT_PUSH: begin
                  if (pos_eff != '0) begin
                     status_in = ST_DUP;
                  end else if (count_ff == CNT_W'(HEAP_SLOTS)) begin
                     status_in = ST_FULL;
                  end else begin
                     count_in = count_ff + 1'b1;
                     cur_idx_in = count_ff + 1'b1;
                     cur_in.key = key_ff;
                     cur_in.prio = prio_ff;
                  end
               end
               ACT_POP: begin
                  if (count_ff == '0) begin
                     status_in = ST_EMPTY;
                  end else begin
                     pos_valid_in[root_ff.key] = 1'b0;
                     slot_ridx = count_ff;
                  end
               end
               default: begin
                  if (pos_eff == '0) begin
                     status_in = ST_ABSENT;
                  end else begin
                     slot_ridx = pos_eff;
                     cur_idx_in = pos_eff;
                  end
               end
            endcase
         end
         S_POP_RD: begin
            count_in = count_ff - 1'b1;
            cur_in = slot_rdata;
            cur_idx_in = CNT_W'(1);
         end
         S_UPD_RD: begin
            cur_in.key = slot_rdata.key;
            cur_in.prio = prio_ff;
            queried_in = prio_ff;
         end
         S_QRY_RD: queried_in = slot_rdata.prio;
         S_UP: begin
            slot_ridx = cur_idx_ff >> 1;
            if (cur_idx_ff == CNT_W'(1)) begin
               slot_we = 1'b1;
               pos_we = 1'b1;
               pos_valid_in[cur_ff.key] = 1'b1;
            end
         end
         S_UP_CMP: begin
            slot_we = 1'b1;
            pos_we = 1'b1;
            if (cur_ff.prio < slot_rdata.prio) begin
               slot_wdata = slot_rdata;
               pos_waddr = slot_rdata.key;
               pos_valid_in[slot_rdata.key] = 1'b1;
               cur_idx_in = cur_idx_ff >> 1;
            end else begin
               pos_valid_in[cur_ff.key] = 1'b1;
            end
         end
         S_DN: begin
            slot_ridx = left_idx[CNT_W-1:0];
            if (left_idx > {1'b0, count_ff}) begin
               slot_we = 1'b1;
               pos_we = 1'b1;
               pos_valid_in[cur_ff.key] = 1'b1;
            end
         end
         S_DN_L: begin
            best_in = slot_rdata;
            best_idx_in = left_idx[CNT_W-1:0];
            slot_ridx = right_idx[CNT_W-1:0];
         end
         S_DN_R: begin
            if (slot_rdata.prio < best_ff.prio) begin
               best_in = slot_rdata;
               best_idx_in = right_idx[CNT_W-1:0];
            end
         end
         S_DN_CMP: begin
            slot_we = 1'b1;
            pos_we = 1'b1;
            if (best_ff.prio < cur_ff.prio) begin
               slot_wdata = best_ff;
               pos_waddr = best_ff.key;
               pos_valid_in[best_ff.key] = 1'b1;
               cur_idx_in = best_idx_ff;
            end else begin
               pos_valid_in[cur_ff.key] = 1'b1;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = '0;
               rsp_data_in[2:0] = status_ff;
               if (count_ff != '0) begin
                  rsp_data_in[8:3] = root_ff.key;
                  rsp_data_in[40:9] = root_ff.prio;
               end
               rsp_data_in[41] = (count_ff == '0);
               rsp_data_in[48:42] = count_ff;
               rsp_data_in[80:49] = queried_ff;
            end
         end
         default: ;
      endcase
   end

   assign root_in = (slot_we && slot_widx == CNT_W'(1)) ? slot_wdata : root_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         pos_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pos_valid_ff <= pos_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff <= act_in;
      key_ff <= key_in;
      prio_ff <= prio_in;
      cur_idx_ff <= cur_idx_in;
      cur_ff <= cur_in;
      best_idx_ff <= best_idx_in;
      best_ff <= best_in;
      status_ff <= status_in;
      queried_ff <= queried_in;
      root_ff <= root_in;
      rsp_data_ff <= rsp_data_in;
   end

   `IMHQ_NEVER(a_count_range, count_ff > CNT_W'(HEAP_SLOTS), "Item count exceeds heap size.")
   `IMHQ_ASSERT(a_rsp_from_done, $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE),
      "Response beat raised outside completion.")
   `IMHQ_ASSERT(a_sift_in_heap,
      (state_ff == S_DN || state_ff == S_UP) |-> (cur_idx_ff != '0 && cur_idx_ff <= count_ff),
      "Sift index left the filled heap.")
   `IMHQ_ASSERT(a_empty_pop_keeps,
      (state_ff == S_POS && act_ff == ACT_POP && count_ff == '0) |=> (count_ff == '0),
      "Pop of an empty heap changed the count.")
endmodule

[tb/testbench.sv]
// Self-checking stream testbench for the indexed min-heap priority queue.
`timescale 1ns / 1ps
module testbench;
   import imhq_pkg::*;

   typedef struct packed {
      logic [31:0] prio;
      logic [5:0] key;
      action_type act;
   } heap_request;

   typedef struct {
      status_type status;
      logic [5:0] front_key;
      logic [31:0] front_prio;
      logic heap_empty;
      logic [6:0] item_count;
      logic [31:0] queried_prio;
   } heap_answer;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   heap_request pending_requests[1024];
   heap_answer expected_answers[1024];
   int unsigned pend_wr = 0;
   int unsigned pend_rd = 0;
   int unsigned exp_wr = 0;
   int unsigned exp_rd = 0;
   int unsigned error_count = 0;
   int unsigned answers_seen = 0;
   int unsigned send_gap = 0;
   int unsigned recv_gap = 0;
   int unsigned hold_off = 0;
   bit stimulus_done = 1'b0;
   bit idle_sender = 1'b1;
   bit idle_receiver = 1'b1;
   int unsigned op_seen[4];

   logic [5:0] model_key[1:64];
   logic signed [31:0] model_prio[1:64];
   int unsigned model_pos[64];
   int unsigned model_fill = 0;

   indexed_min_heap_queue_unit i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #4 clock = ~clock;

   function automatic void swap_slots(int unsigned a, int unsigned b);
      logic [5:0] tk;
      logic signed [31:0] tp;
      tk = model_key[a];
      tp = model_prio[a];
      model_key[a] = model_key[b];
      model_prio[a] = model_prio[b];
      model_key[b] = tk;
      model_prio[b] = tp;
      model_pos[model_key[a]] = a;
      model_pos[model_key[b]] = b;
   endfunction

   function automatic void raise_slot(int unsigned i);
      while (i > 1 && model_prio[i] < model_prio[i / 2]) begin
         swap_slots(i, i / 2);
         i = i / 2;
      end
   endfunction

   function automatic void lower_slot(int unsigned i);
      int unsigned best;
      while (2 * i <= model_fill) begin
         best = 2 * i;
         if (best + 1 <= model_fill && model_prio[best + 1] < model_prio[best]) best = best + 1;
         if (model_prio[best] < model_prio[i]) begin
            swap_slots(i, best);
            i = best;
         end else begin
            break;
         end
      end
   endfunction

   function automatic heap_answer apply_request(heap_request r);
      heap_answer a;
      int unsigned p;
      logic signed [31:0] newp;
      logic signed [31:0] oldp;
      p = model_pos[r.key];
      newp = r.prio;
      a.status = ST_OK;
      a.queried_prio = '0;
      case (r.act)
         ACT_PUSH: begin
            if (p != 0) a.status = ST_DUP;
            else if (model_fill >= 64) a.status = ST_FULL;
            else begin
               model_fill++;
               model_key[model_fill] = r.key;
               model_prio[model_fill] = newp;
               model_pos[r.key] = model_fill;
               raise_slot(model_fill);
            end
         end
         ACT_POP: begin
            if (model_fill == 0) a.status = ST_EMPTY;
            else begin
               model_pos[model_key[1]] = 0;
               model_key[1] = model_key[model_fill];
               model_prio[1] = model_prio[model_fill];
               model_fill--;
               if (model_fill > 0) begin
                  model_pos[model_key[1]] = 1;
                  lower_slot(1);
               end
            end
         end
         ACT_UPDATE: begin
            if (p == 0) a.status = ST_ABSENT;
            else begin
               oldp = model_prio[p];
               model_prio[p] = newp;
               if (oldp < newp) lower_slot(p);
               else raise_slot(p);
               a.queried_prio = newp;
            end
         end
         default: begin
            if (p == 0) a.status = ST_ABSENT;
            else a.queried_prio = model_prio[p];
         end
      endcase
      a.front_key = model_fill != 0 ? model_key[1] : '0;
      a.front_prio = model_fill != 0 ? model_prio[1] : '0;
      a.heap_empty = model_fill == 0;
      a.item_count = model_fill[6:0];
      return a;
   endfunction

   function automatic logic [31:0] pick_prio();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom_range(0, 7);
         3: return $urandom_range(0, 15) - 8;
         default: return $urandom;
      endcase
   endfunction

   function automatic void add_request(action_type act, int unsigned key, logic [31:0] prio);
      heap_request r;
      r.act = act;
      r.key = key[5:0];
      r.prio = prio;
      pending_requests[pend_wr] = r;
      pend_wr++;
   endfunction

   // The driver starts a fresh gap after each accepted beat.
   always @(posedge clock) begin
      heap_request r;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            r = heap_request'(req_tdata);
            expected_answers[exp_wr] = apply_request(r);
            exp_wr++;
            op_seen[r.act]++;
            send_gap <= idle_sender ? $urandom_range(0, 16) : 0;
         end
         if ((!req_tvalid || req_tready) && pend_rd != pend_wr &&
             (send_gap == 0 || (req_tvalid && req_tready && !idle_sender))) begin
            req_tvalid <= 1'b1;
            req_tdata <= pending_requests[pend_rd];
            pend_rd++;
         end else if (!req_tvalid || req_tready) begin
            req_tvalid <= 1'b0;
            if (!(req_tvalid && req_tready) && send_gap != 0) send_gap <= send_gap - 1;
         end
      end
   end

   always @(posedge clock) begin
      heap_answer e;
      int unsigned gap;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            answers_seen++;
            if (exp_rd == exp_wr) begin
               $error("response beat with no request outstanding");
               error_count++;
            end else begin
               e = expected_answers[exp_rd];
               exp_rd++;
               if (rsp_tdata[2:0] !== e.status) begin
                  $error("status expected %0d actual %0d", e.status, rsp_tdata[2:0]);
                  error_count++;
               end
               if (rsp_tdata[8:3] !== e.front_key) begin
                  $error("front_key expected %0d actual %0d", e.front_key, rsp_tdata[8:3]);
                  error_count++;
               end
               if (rsp_tdata[40:9] !== e.front_prio) begin
                  $error("front_prio expected %0h actual %0h", e.front_prio, rsp_tdata[40:9]);
                  error_count++;
               end
               if (rsp_tdata[41] !== e.heap_empty) begin
                  $error("heap_empty expected %0d actual %0d", e.heap_empty, rsp_tdata[41]);
                  error_count++;
               end
               if (rsp_tdata[48:42] !== e.item_count) begin
                  $error("item_count expected %0d actual %0d", e.item_count, rsp_tdata[48:42]);
                  error_count++;
               end
               if (rsp_tdata[80:49] !== e.queried_prio) begin
                  $error("queried_prio expected %0h actual %0h", e.queried_prio,
                         rsp_tdata[80:49]);
                  error_count++;
               end
            end
         end
         if (hold_off != 0) begin
            hold_off <= hold_off - 1;
            rsp_tready <= 1'b0;
         end else if (recv_gap != 0) begin
            recv_gap <= recv_gap - 1;
            rsp_tready <= 1'b0;
         end else if (rsp_tvalid && rsp_tready && idle_receiver) begin
            gap = $urandom_range(0, 16);
            recv_gap <= gap;
            rsp_tready <= (gap == 0);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      int unsigned k;
      int unsigned n;
      for (int i = 0; i < 64; i++) model_pos[i] = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      add_request(ACT_POP, 0, 0);
      add_request(ACT_QUERY, 5, 0);
      add_request(ACT_UPDATE, 5, 1);
      add_request(ACT_PUSH, 63, 32'h7fff_ffff);
      add_request(ACT_PUSH, 0, 32'h8000_0000);
      add_request(ACT_PUSH, 0, 3);
      add_request(ACT_PUSH, 7, 32'h8000_0000);
      add_request(ACT_PUSH, 42, 32'h5555_aaaa);
      add_request(ACT_PUSH, 21, 32'haaaa_5555);
      add_request(ACT_QUERY, 63, 0);
      add_request(ACT_UPDATE, 63, 32'h8000_0000);
      add_request(ACT_UPDATE, 0, 32'h7fff_ffff);
      add_request(ACT_UPDATE, 42, 32'h5555_aaaa);
      add_request(ACT_POP, 9, 0);
      add_request(ACT_POP, 0, 0);
      add_request(ACT_POP, 0, 0);
      add_request(ACT_POP, 0, 0);
      add_request(ACT_POP, 0, 0);
      add_request(ACT_POP, 0, 0);
      // Fill every slot, then push a key already held, which is refused as a duplicate.
      for (int i = 0; i < 64; i++) add_request(ACT_PUSH, i, pick_prio());
      add_request(ACT_PUSH, 3, 1);
      for (int i = 0; i < 20; i++) add_request(ACT_UPDATE, $urandom_range(0, 63), pick_prio());
      for (int i = 0; i < 66; i++) add_request(ACT_POP, $urandom_range(0, 63), 0);
      // Random phase: a random mix of pushes, pops, updates and queries with random keys.
      n = 0;
      while (n < 350) begin
         k = $urandom_range(0, 99);
         if (k < 40) add_request(ACT_PUSH, $urandom_range(0, 63), pick_prio());
         else if (k < 65) add_request(ACT_POP, $urandom_range(0, 63), $urandom);
         else if (k < 85) add_request(ACT_UPDATE, $urandom_range(0, 63), pick_prio());
         else add_request(ACT_QUERY, $urandom_range(0, 63), $urandom);
         n++;
      end
      // A long receiver stall while requests keep coming, then a stretch with no idling.
      repeat (200) @(posedge clock);
      hold_off <= 300;
      wait (pend_wr - pend_rd < 120);
      idle_sender <= 1'b0;
      idle_receiver <= 1'b0;
      wait (pend_wr - pend_rd < 40);
      idle_sender <= 1'b1;
      idle_receiver <= 1'b1;
      wait (pend_rd == pend_wr && !req_tvalid);
      wait (exp_rd == exp_wr);
      repeat (40) @(posedge clock);
      $display("Sent %0d push, %0d pop, %0d update and %0d query beats; %0d responses checked.",
               op_seen[0], op_seen[1], op_seen[2], op_seen[3], answers_seen);
      if (error_count == 0 && exp_rd == exp_wr)
         $display("indexed_min_heap_queue_unit verification clean");
      else
         $display("indexed_min_heap_queue_unit verification failed");
      $finish;
   end

   initial begin
      #3000000;
      $display("indexed_min_heap_queue_unit verification failed");
      $finish;
   end
endmodule
